FILE: rtl/core/tac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tac_pkg;

  typedef enum logic [1:0] {
    MODE_SYNTH = 2'd0,
    MODE_TOPO  = 2'd1,
    MODE_REL   = 2'd2,
    MODE_PRED  = 2'd3
  } mode_e;

  localparam logic [1:0] CfgColorMode   = 2'd0;
  localparam logic [1:0] CfgAircraftAlt = 2'd1;
  localparam logic [1:0] CfgVertSpeed   = 2'd2;

  localparam int unsigned TerrainW = 19;
  localparam int unsigned CfgW     = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned AcW      = 17;
  localparam int unsigned VsW      = 15;
  localparam int unsigned ColourW  = 8;
  localparam int unsigned ProdW    = 37;
  localparam int unsigned DW       = 24;

  localparam logic signed [TerrainW-1:0] FtPerMQ16 = 19'sd215013;

  localparam int unsigned TopoBands = 11;
  localparam int unsigned RelBands  = 4;

  // band index of the synthetic ramp: d / 100 as d * 1311 >> 17 for d below 3200
  localparam int unsigned SynDW       = 12;
  localparam int unsigned KpW         = 23;
  localparam int unsigned SynIdxShift = 17;
  localparam logic [10:0] RecipHundred = 11'd1311;

  typedef logic signed [DW-1:0] ft_t;

  localparam ft_t SynOffsetFt = 24'sd1000;
  localparam ft_t SynTopFt    = 24'sd3200;

  typedef struct packed {
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic  valid;
    logic  wet;
    mode_e mode;
    ft_t   delta;
    ft_t   ceil_ft;
  } sample_t;

  localparam rgb_t WetRgb     = '{red: 8'd127, green: 8'd127, blue: 8'd255};
  localparam rgb_t SynLowRgb  = '{red: 8'd0,   green: 8'd12,  blue: 8'd0};
  localparam rgb_t SynHighRgb = '{red: 8'd229, green: 8'd229, blue: 8'd229};

  function automatic ft_t topo_limit(input logic [3:0] idx);
    ft_t lim;
    case (idx)
      4'd0:    lim = ft_t'(0);
      4'd1:    lim = ft_t'(1000);
      4'd2:    lim = ft_t'(2000);
      4'd3:    lim = ft_t'(3000);
      4'd4:    lim = ft_t'(5000);
      4'd5:    lim = ft_t'(7000);
      4'd6:    lim = ft_t'(9000);
      4'd7:    lim = ft_t'(11000);
      4'd8:    lim = ft_t'(13000);
      4'd9:    lim = ft_t'(15000);
      default: lim = ft_t'(17000);
    endcase
    return lim;
  endfunction

  function automatic ft_t rel_limit(input logic [1:0] idx);
    ft_t lim;
    case (idx)
      2'd0:    lim = ft_t'(1500);
      2'd1:    lim = ft_t'(-100);
      2'd2:    lim = ft_t'(-1000);
      default: lim = ft_t'(-2000);
    endcase
    return lim;
  endfunction

  // tenths of 255, up to 204, as bytes
  function automatic logic [ColourW-1:0] ramp(input logic [3:0] n);
    logic [ColourW-1:0] v;
    case (n)
      4'd0:    v = 8'd0;
      4'd1:    v = 8'd25;
      4'd2:    v = 8'd51;
      4'd3:    v = 8'd76;
      4'd4:    v = 8'd102;
      4'd5:    v = 8'd127;
      4'd6:    v = 8'd153;
      4'd7:    v = 8'd178;
      default: v = 8'd204;
    endcase
    return v;
  endfunction

  function automatic rgb_t syn_rgb(input logic [4:0] k);
    rgb_t c;
    c = '0;
    if (k < 5'd8) begin
      c.green = ramp(4'(k + 5'd1));
    end else if (k < 5'd16) begin
      c.red   = ramp(4'(k - 5'd7));
      c.green = ramp(4'd8);
    end else if (k < 5'd24) begin
      c.red   = ramp(4'd8);
      c.green = ramp(4'(5'd23 - k));
    end else begin
      c.red   = ramp(4'd8);
      c.green = ramp(4'(k - 5'd23));
      c.blue  = ramp(4'(k - 5'd23));
    end
    return c;
  endfunction

  function automatic rgb_t topo_rgb(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{red: 8'd214, green: 8'd225, blue: 8'd201};
      4'd1:    c = '{red: 8'd185, green: 8'd213, blue: 8'd185};
      4'd2:    c = '{red: 8'd158, green: 8'd199, blue: 8'd171};
      4'd3:    c = '{red: 8'd224, green: 8'd214, blue: 8'd204};
      4'd4:    c = '{red: 8'd213, green: 8'd202, blue: 8'd161};
      4'd5:    c = '{red: 8'd217, green: 8'd192, blue: 8'd146};
      4'd6:    c = '{red: 8'd196, green: 8'd160, blue: 8'd110};
      4'd7:    c = '{red: 8'd197, green: 8'd148, blue: 8'd94};
      4'd8:    c = '{red: 8'd188, green: 8'd136, blue: 8'd75};
      4'd9:    c = '{red: 8'd177, green: 8'd124, blue: 8'd60};
      4'd10:   c = '{red: 8'd158, green: 8'd103, blue: 8'd32};
      default: c = '{red: 8'd110, green: 8'd82,  blue: 8'd0};
    endcase
    return c;
  endfunction

  function automatic rgb_t rel_rgb(input logic [2:0] idx);
    rgb_t c;
    case (idx)
      3'd0:    c = '{red: 8'd123, green: 8'd0,   blue: 8'd21};
      3'd1:    c = '{red: 8'd244, green: 8'd0,   blue: 8'd43};
      3'd2:    c = '{red: 8'd251, green: 8'd255, blue: 8'd168};
      3'd3:    c = '{red: 8'd71,  green: 8'd160, blue: 8'd112};
      default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/terrain_altitude_colorizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Terrain map colouriser: one pixel colour per terrain sample, one sample per clock while
// the output is not stalled. The pipeline is input register, the single 19x19
// altitude-to-feet multiplier, feet rounding and reference subtract, band compares, and
// colour table with output register, so the sustained rate is one request per cycle
// unless stalled. An output stall while the output is valid freezes every stage at once and
// is passed back as the input stall; nothing is dropped or repeated. Configuration
// registers (colour mode, aircraft altitude, vertical speed) are written through the plain
// write port and must only change while no request is in flight.
module terrain_altitude_colorizer_top #(
  parameter int unsigned ALT_FRAC_BITS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tac_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [tac_pkg::CfgW-1:0]             cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [tac_pkg::TerrainW-1:0]  terrain_alt_i,
  input  logic                                 is_wet_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [tac_pkg::ColourW-1:0]          red_o,
  output logic [tac_pkg::ColourW-1:0]          green_o,
  output logic [tac_pkg::ColourW-1:0]          blue_o
);
  import tac_pkg::*;

  localparam int unsigned Shift = 16 + ALT_FRAC_BITS;
  localparam logic signed [ProdW:0] RoundUp = {{(ProdW + 1 - Shift){1'b0}}, {Shift{1'b1}}};

  mode_e                       mode_q;
  logic signed [AcW-1:0]       ac_q;
  logic signed [VsW-1:0]       vs_q;

  logic                        en;
  logic                        v1_q, v2_q, v3_q;
  logic signed [TerrainW-1:0]  terrain_q;
  logic                        wet1_q, wet2_q, wet3_q;
  logic signed [ProdW-1:0]     prod_d, prod_q;
  logic signed [ProdW:0]       ceil_sum;
  ft_t                         floor_ft, ceil_d, ceil_q, ref_ft, delta_d, delta_q;
  mode_e                       mode3_q;
  sample_t                     sample;
  rgb_t                        rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TOPO;
      ac_q   <= '0;
      vs_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgColorMode:   mode_q <= mode_e'(cfg_data_i[1:0]);
        CfgAircraftAlt: ac_q   <= signed'(cfg_data_i[AcW-1:0]);
        CfgVertSpeed:   vs_q   <= signed'(cfg_data_i[VsW-1:0]);
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // feet at scale 2^Shift, then floor and ceiling to whole feet
  assign prod_d   = ProdW'(terrain_q * FtPerMQ16);
  assign floor_ft = ft_t'(prod_q >>> Shift);
  assign ceil_sum = (ProdW + 1)'(prod_q) + RoundUp;
  assign ceil_d   = ft_t'(ceil_sum >>> Shift);

  always_comb begin
    case (mode_q)
      MODE_SYNTH: ref_ft = ft_t'(ac_q) - SynOffsetFt;
      MODE_PRED:  ref_ft = ft_t'(ac_q) + ft_t'(vs_q);
      default:    ref_ft = ft_t'(ac_q);
    endcase
  end

  assign delta_d = floor_ft - ref_ft;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      terrain_q <= terrain_alt_i;
      wet1_q    <= is_wet_i;
      prod_q    <= prod_d;
      wet2_q    <= wet1_q;
      wet3_q    <= wet2_q;
      mode3_q   <= mode_q;
      delta_q   <= delta_d;
      ceil_q    <= ceil_d;
    end
  end

  always_comb begin
    sample.valid   = v3_q;
    sample.wet     = wet3_q;
    sample.mode    = mode3_q;
    sample.delta   = delta_q;
    sample.ceil_ft = ceil_q;
  end

  tac_shade u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .sample_i (sample),
    .valid_o  (out_valid_o),
    .rgb_o    (rgb)
  );

  assign red_o   = rgb.red;
  assign green_o = rgb.green;
  assign blue_o  = rgb.blue;

endmodule

`default_nettype wire

FILE: rtl/core/tac_shade.sv
`timescale 1ns / 1ps
`default_nettype none

module tac_shade (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  tac_pkg::sample_t sample_i,
  output logic             valid_o,
  output tac_pkg::rgb_t    rgb_o
);
  import tac_pkg::*;

  typedef struct packed {
    logic           wet;
    mode_e          mode;
    logic [3:0]     topo_idx;
    logic [2:0]     rel_idx;
    logic           below;
    logic           above;
    logic [KpW-1:0] kp;
  } band_t;

  logic [TopoBands-1:0] topo_le;
  logic [RelBands-1:0]  rel_ge;
  band_t                band_d, band_q;
  logic                 band_valid_q;
  rgb_t                 rgb_d, rgb_q;
  logic                 rgb_valid_q;
  logic [4:0]           syn_idx;

  // band search
  always_comb begin
    for (int i = 0; i < TopoBands; i++) begin
      topo_le[i] = sample_i.ceil_ft <= topo_limit(4'(i));
    end
    for (int i = 0; i < RelBands; i++) begin
      rel_ge[i] = sample_i.delta >= rel_limit(2'(i));
    end
    band_d.wet      = sample_i.wet;
    band_d.mode     = sample_i.mode;
    band_d.topo_idx = 4'(TopoBands);
    for (int i = TopoBands - 1; i >= 0; i--) begin
      if (topo_le[i]) begin
        band_d.topo_idx = 4'(i);
      end
    end
    band_d.rel_idx = 3'(RelBands);
    for (int i = RelBands - 1; i >= 0; i--) begin
      if (rel_ge[i]) begin
        band_d.rel_idx = 3'(i);
      end
    end
    band_d.below = sample_i.delta[DW-1];
    band_d.above = sample_i.delta >= SynTopFt;
    band_d.kp    = KpW'(sample_i.delta[SynDW-1:0]) * KpW'(RecipHundred);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_valid_q <= 1'b0;
      rgb_valid_q  <= 1'b0;
    end else if (en_i) begin
      band_valid_q <= sample_i.valid;
      rgb_valid_q  <= band_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      band_q <= band_d;
      rgb_q  <= rgb_d;
    end
  end

  // colour pick
  assign syn_idx = band_q.kp[SynIdxShift+4:SynIdxShift];

  always_comb begin
    if (band_q.wet) begin
      rgb_d = WetRgb;
    end else begin
      case (band_q.mode)
        MODE_SYNTH: begin
          if (band_q.below) begin
            rgb_d = SynLowRgb;
          end else if (band_q.above) begin
            rgb_d = SynHighRgb;
          end else begin
            rgb_d = syn_rgb(syn_idx);
          end
        end
        MODE_TOPO: rgb_d = topo_rgb(band_q.topo_idx);
        default:   rgb_d = rel_rgb(band_q.rel_idx);
      endcase
    end
  end

  assign valid_o = rgb_valid_q;
  assign rgb_o   = rgb_q;

endmodule

`default_nettype wire

FILE: rtl/core/tac_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tac_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tac_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [tac_pkg::CfgW-1:0]             cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_o,
  input  logic signed [tac_pkg::TerrainW-1:0]  terrain_alt_i,
  input  logic                                 is_wet_i,
  input  logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  logic [tac_pkg::ColourW-1:0]          red_o,
  input  logic [tac_pkg::ColourW-1:0]          green_o,
  input  logic [tac_pkg::ColourW-1:0]          blue_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !in_stall_o ##1 !in_stall_o ##1 !in_stall_o
      ##1 !in_stall_o |=> out_valid_o)
    else $error("request did not reach the output in five cycles");

  a_water_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && blue_o == 8'd255 |-> red_o == 8'd127 && green_o == 8'd127)
    else $error("full blue outside the water colour");

endmodule

bind terrain_altitude_colorizer_top tac_checker u_tac_checker (.*);

`default_nettype wire

FILE: dv/terrain_altitude_colorizer_checker.sv
`timescale 1ns / 1ps

module terrain_altitude_colorizer_checker
  import tac_pkg::*;
#(
  parameter int unsigned ALT_FRAC_BITS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgW-1:0]            cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [TerrainW-1:0] terrain_alt_i,
  input  logic                       is_wet_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [ColourW-1:0]         red_i,
  input  logic [ColourW-1:0]         green_i,
  input  logic [ColourW-1:0]         blue_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam longint FtPerMetreQ16 = 215013;

  mode_e                 colour_mode;
  logic signed [AcW-1:0] aircraft_ft;
  logic signed [VsW-1:0] climb_ft;
  rgb_t                  pixel_q[$];
  rgb_t                  want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report(input string what, input int want_v, input int got_v);
    fail_count_o++;
    $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want_v, got_v);
  endtask

  function automatic logic [ColourW-1:0] ramp_byte(input int n);
    case (n)
      0:       return 8'd0;
      1:       return 8'd25;
      2:       return 8'd51;
      3:       return 8'd76;
      4:       return 8'd102;
      5:       return 8'd127;
      6:       return 8'd153;
      7:       return 8'd178;
      default: return 8'd204;
    endcase
  endfunction

  // green rises, red rises, green falls, then green and blue rise until all three reach 204
  function automatic rgb_t synth_band_colour(input int k);
    rgb_t c;
    c = '0;
    if (k < 8) begin
      c.green = ramp_byte(k + 1);
    end else if (k < 16) begin
      c.red   = ramp_byte(k - 7);
      c.green = ramp_byte(8);
    end else if (k < 24) begin
      c.red   = ramp_byte(8);
      c.green = ramp_byte(23 - k);
    end else begin
      c.red   = ramp_byte(8);
      c.green = ramp_byte(k - 23);
      c.blue  = ramp_byte(k - 23);
    end
    return c;
  endfunction

  function automatic longint topo_ceiling_ft(input int band);
    case (band)
      0:       return 0;
      1:       return 1000;
      2:       return 2000;
      3:       return 3000;
      4:       return 5000;
      5:       return 7000;
      6:       return 9000;
      7:       return 11000;
      8:       return 13000;
      9:       return 15000;
      default: return 17000;
    endcase
  endfunction

  function automatic rgb_t topo_band_colour(input int band);
    case (band)
      0:       return '{8'd214, 8'd225, 8'd201};
      1:       return '{8'd185, 8'd213, 8'd185};
      2:       return '{8'd158, 8'd199, 8'd171};
      3:       return '{8'd224, 8'd214, 8'd204};
      4:       return '{8'd213, 8'd202, 8'd161};
      5:       return '{8'd217, 8'd192, 8'd146};
      6:       return '{8'd196, 8'd160, 8'd110};
      7:       return '{8'd197, 8'd148, 8'd94};
      8:       return '{8'd188, 8'd136, 8'd75};
      9:       return '{8'd177, 8'd124, 8'd60};
      10:      return '{8'd158, 8'd103, 8'd32};
      default: return '{8'd110, 8'd82, 8'd0};
    endcase
  endfunction

  function automatic longint clearance_floor_ft(input int band);
    case (band)
      0:       return 1500;
      1:       return -100;
      2:       return -1000;
      default: return -2000;
    endcase
  endfunction

  function automatic rgb_t clearance_colour(input int band);
    case (band)
      0:       return '{8'd123, 8'd0, 8'd21};
      1:       return '{8'd244, 8'd0, 8'd43};
      2:       return '{8'd251, 8'd255, 8'd168};
      3:       return '{8'd71, 8'd160, 8'd112};
      default: return '{8'd0, 8'd0, 8'd0};
    endcase
  endfunction

  // feet kept exactly at a scale of 2^(16 + frac bits)
  function automatic rgb_t predict_pixel(input logic signed [TerrainW-1:0] alt, input logic wet);
    longint unit;
    longint feet;
    longint delta;
    int     band;
    unit = longint'(1) << (16 + ALT_FRAC_BITS);
    feet = longint'(alt) * FtPerMetreQ16;
    if (wet) begin
      return '{8'd127, 8'd127, 8'd255};
    end
    case (colour_mode)
      MODE_SYNTH: begin
        delta = feet - (longint'(aircraft_ft) - 1000) * unit;
        if (delta < 0) begin
          return '{8'd0, 8'd12, 8'd0};
        end else if (delta >= 3200 * unit) begin
          return '{8'd229, 8'd229, 8'd229};
        end
        return synth_band_colour(int'(delta / (100 * unit)));
      end
      MODE_TOPO: begin
        band = 0;
        while (band < 11 && feet > topo_ceiling_ft(band) * unit) begin
          band++;
        end
        return topo_band_colour(band);
      end
      default: begin
        delta = feet - longint'(aircraft_ft) * unit;
        if (colour_mode == MODE_PRED) begin
          delta = delta - longint'(climb_ft) * unit;
        end
        band = 0;
        while (band < 4 && delta < clearance_floor_ft(band) * unit) begin
          band++;
        end
        return clearance_colour(band);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_mode = MODE_TOPO;
      aircraft_ft = '0;
      climb_ft    = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          report("pixel with no request outstanding", 0, 0);
        end else begin
          want = pixel_q.pop_front();
          if (red_i !== want.red) begin
            report("red", want.red, red_i);
          end
          if (green_i !== want.green) begin
            report("green", want.green, green_i);
          end
          if (blue_i !== want.blue) begin
            report("blue", want.blue, blue_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pixel_q = {pixel_q, predict_pixel(terrain_alt_i, is_wet_i)};
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgColorMode:   colour_mode = mode_e'(cfg_data_i[1:0]);
          CfgAircraftAlt: aircraft_ft = cfg_data_i[AcW-1:0];
          CfgVertSpeed:   climb_ft = cfg_data_i[VsW-1:0];
          default: ;
        endcase
      end
      pending_o = pixel_q.size();
    end
  end

endmodule

FILE: dv/terrain_altitude_colorizer_top_test.sv
`timescale 1ns / 1ps

module terrain_altitude_colorizer_top_test;
  import tac_pkg::*;

  localparam int     CycleLimit    = 300000;
  localparam int     HoldCycles    = 300;
  localparam int     PhaseCount    = 16;
  localparam int     PhaseRequests = 85;
  localparam longint FtPerMetreQ16 = 215013;
  localparam longint AltMin        = -262144;
  localparam longint AltMax        = 262143;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [CfgW-1:0]            cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [TerrainW-1:0] terrain_alt_i = '0;
  logic                       is_wet_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [ColourW-1:0]         red_o;
  logic [ColourW-1:0]         green_o;
  logic [ColourW-1:0]         blue_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent = 0;
  int settings = 0;
  logic quiet = 1'b0;
  logic gaps_on = 1'b1;
  logic hold_req = 1'b0;

  mode_e                 mode_sel = MODE_TOPO;
  logic signed [AcW-1:0] ac_ft = '0;
  logic signed [VsW-1:0] vs_ft = '0;

  terrain_altitude_colorizer_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .terrain_alt_i(terrain_alt_i),
    .is_wet_i     (is_wet_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  terrain_altitude_colorizer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .terrain_alt_i(terrain_alt_i),
    .is_wet_i     (is_wet_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // smallest terrain sample whose height in feet reaches ft
  function automatic longint first_alt_reaching(input longint ft);
    longint num;
    longint q;
    num = ft <<< 20;
    q = num / FtPerMetreQ16;
    if (q * FtPerMetreQ16 < num) begin
      q++;
    end
    return q;
  endfunction

  function automatic logic signed [TerrainW-1:0] pick_alt();
    longint base;
    longint a;
    int     sel;
    sel = $urandom_range(0, 9);
    case (mode_sel)
      MODE_SYNTH: base = longint'(ac_ft) - 1000;
      MODE_TOPO:  base = 0;
      MODE_REL:   base = longint'(ac_ft);
      default:    base = longint'(ac_ft) + longint'(vs_ft);
    endcase
    if (sel == 0) begin
      return TerrainW'($urandom);
    end
    if (sel < 3) begin
      return TerrainW'(longint'($urandom_range(0, 152000)) - 8000);
    end
    a = first_alt_reaching(base);
    case (mode_sel)
      MODE_SYNTH: a = a + longint'($urandom_range(0, 20000)) - 2000;
      MODE_TOPO:  a = a + longint'($urandom_range(0, 90000)) - 1000;
      default:    a = a + longint'($urandom_range(0, 24000)) - 14000;
    endcase
    if (a < AltMin) begin
      a = AltMin;
    end else if (a > AltMax) begin
      a = AltMax;
    end
    return TerrainW'(a);
  endfunction

  task automatic send_request(input longint alt, input logic wet);
    int gap;
    @(negedge clk_i);
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    terrain_alt_i = TerrainW'(alt);
    is_wet_i      = wet;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_edge(input longint ft);
    longint a;
    a = first_alt_reaching(ft);
    send_request(a - 1, 1'b0);
    send_request(a, 1'b0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_setting(input mode_e m, input logic signed [AcW-1:0] ac,
                               input logic signed [VsW-1:0] vs);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk_i);
    write_reg(CfgColorMode, {15'($urandom), m});
    write_reg(CfgAircraftAlt, ac);
    write_reg(CfgVertSpeed, {2'($urandom), vs});
    mode_sel = m;
    ac_ft    = ac;
    vs_ft    = vs;
    settings++;
  endtask

  // output side: random stall bursts, one long hold on request
  initial begin : out_side
    int   left;
    logic stall_bit;
    left      = 0;
    stall_bit = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req    = 1'b0;
      end else if (quiet) begin
        out_stall_i = 1'b0;
      end else begin
        if (left == 0) begin
          stall_bit = ($urandom_range(0, 2) == 0);
          if (stall_bit) begin
            left = $urandom_range(1, 10);
          end else begin
            left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
          end
        end
        out_stall_i = stall_bit;
        left--;
      end
    end
  end

  initial begin : stimulus
    mode_e                 m;
    logic signed [AcW-1:0] ac;
    logic signed [VsW-1:0] vs;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // topographic after reset: field extremes, band edges, water
    send_request(0, 1'b0);
    send_request(1, 1'b0);
    send_request(-8000, 1'b0);
    send_request(144000, 1'b0);
    send_request(AltMin, 1'b0);
    send_request(AltMax, 1'b0);
    send_request(0, 1'b1);
    send_edge(1000);
    send_edge(17000);

    // synthetic: below reference, first band, top of the ramp, water
    apply_setting(MODE_SYNTH, 17'sd1000, 15'sd0);
    send_request(-1, 1'b0);
    send_request(0, 1'b0);
    send_edge(100);
    send_edge(3200);
    send_request(AltMax, 1'b1);

    apply_setting(MODE_REL, 17'sd0, 15'sd0);
    send_edge(1500);
    send_edge(-2000);

    apply_setting(MODE_PRED, -17'sd2000, 15'sd10000);
    send_edge(8000 - 100);
    send_request(AltMin, 1'b1);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin m = MODE_SYNTH; ac = -17'sd2000;  vs = -15'sd10000; end
        1: begin m = MODE_PRED;  ac = 17'sd60000;  vs = 15'sd10000;  end
        2: begin m = MODE_PRED;  ac = -17'sd65536; vs = -15'sd16384; end
        3: begin m = MODE_REL;   ac = 17'sd65535;  vs = 15'sd16383;  end
        4: begin m = MODE_TOPO;  ac = 17'sd0;      vs = 15'sd0;      end
        default: begin
          m  = mode_e'($urandom_range(0, 3));
          ac = ($urandom_range(0, 4) == 0) ? AcW'($urandom)
                                           : AcW'(int'($urandom_range(0, 62000)) - 2000);
          vs = ($urandom_range(0, 4) == 0) ? VsW'($urandom)
                                           : VsW'(int'($urandom_range(0, 20000)) - 10000);
        end
      endcase
      apply_setting(m, ac, vs);
      gaps_on = (p % 3 != 2);
      quiet   = (p >= PhaseCount - 2);
      if (p == 6) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < PhaseRequests; i++) begin
        send_request(pick_alt(), $urandom_range(0, 7) == 0);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    $display("summary: %0d terrain requests over %0d register settings in all four modes,",
             sent, settings);
    $display("summary: including field extremes, band edges, water and one %0d-cycle hold",
             HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tac_pkg.sv
rtl/core/tac_shade.sv
rtl/core/terrain_altitude_colorizer_top.sv
rtl/core/tac_checker.sv
dv/terrain_altitude_colorizer_checker.sv
dv/terrain_altitude_colorizer_top_test.sv
